// File: hdl/owrf_pkg.sv
// Shared types and constants for the overwrite ring FIFO.
// No dependencies; imported by owrf_ptr, overwrite_ring_fifo and the testbench.
package owrf_pkg;

  localparam int OP_W          = 2;
  localparam int BYTE_W        = 8;
  localparam int DEFAULT_DEPTH = 256;

  localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQ  = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

  typedef struct packed {
    logic              strobe;
    logic              ok;
    logic              rd;
    logic [BYTE_W-1:0] count;
  } owrf_res_t;

endpackage

// File: hdl/owrf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module owrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/owrf_ptr.sv
// Pointer and status unit of the overwrite ring FIFO: decodes the operation,
// updates the ring pointers and drives the RAM ports. Depends on owrf_pkg.
module owrf_ptr #(
  parameter int DEPTH = owrf_pkg::DEFAULT_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [owrf_pkg::OP_W-1:0]    op,
  input  logic [owrf_pkg::BYTE_W-1:0]  write_byte,
  input  logic [owrf_pkg::BYTE_W-1:0]  peek_offset,
  output logic                         ram_we,
  output logic [$clog2(DEPTH)-1:0]     ram_waddr,
  output logic [owrf_pkg::BYTE_W-1:0]  ram_wdata,
  output logic [$clog2(DEPTH)-1:0]     ram_raddr,
  output owrf_pkg::owrf_res_t          res
);
  import owrf_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CMP_W = (PTR_W > BYTE_W) ? PTR_W : BYTE_W;

  logic [PTR_W-1:0] wp, wp_next;
  logic [PTR_W-1:0] rp, rp_next;
  logic [PTR_W-1:0] cnt, cnt_next;
  logic             full, empty, peek_hit, ok_next, rd_next;

  assign cnt      = wp - rp;
  assign cnt_next = wp_next - rp_next;
  assign full     = (PTR_W'(wp + 1'b1) == rp);
  assign empty    = (wp == rp);
  assign peek_hit = (CMP_W'(peek_offset) < CMP_W'(cnt));

  assign ram_waddr = wp;
  assign ram_wdata = write_byte;

  always_comb begin
    wp_next   = wp;
    rp_next   = rp;
    ok_next   = 1'b0;
    rd_next   = 1'b0;
    ram_we    = 1'b0;
    ram_raddr = rp;
    if (accept) begin
      unique case (op)
        OP_ENQ: begin
          ram_we  = 1'b1;
          wp_next = PTR_W'(wp + 1'b1);
          if (full) begin
            rp_next = PTR_W'(rp + 1'b1);
          end
          ok_next = 1'b1;
        end
        OP_DEQ: begin
          if (!empty) begin
            rp_next = PTR_W'(rp + 1'b1);
            ok_next = 1'b1;
            rd_next = 1'b1;
          end
        end
        OP_PEEK: begin
          ram_raddr = PTR_W'(rp + PTR_W'(peek_offset));
          if (peek_hit) begin
            ok_next = 1'b1;
            rd_next = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp         <= '0;
      rp         <= '0;
      res.strobe <= 1'b0;
    end else begin
      wp         <= wp_next;
      rp         <= rp_next;
      res.strobe <= accept;
    end
    res.ok    <= ok_next;
    res.rd    <= rd_next;
    res.count <= BYTE_W'(cnt_next);
  end

`ifndef SYNTH
  a_enq_ok: assert property (@(posedge clk) disable iff (rst)
    accept && op == OP_ENQ |=> res.strobe && res.ok && !res.rd)
    else $error("enqueue result not reported as ok");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !accept |=> !res.strobe)
    else $error("result strobe without an accepted item");

  a_enq_wp: assert property (@(posedge clk) disable iff (rst)
    accept && op == OP_ENQ |=> wp == PTR_W'($past(wp) + 1'b1))
    else $error("write pointer did not advance on enqueue");

  a_deq_rp: assert property (@(posedge clk) disable iff (rst)
    accept && op == OP_DEQ && wp != rp |=> rp == PTR_W'($past(rp) + 1'b1))
    else $error("read pointer did not advance on dequeue");

  a_peek_hold: assert property (@(posedge clk) disable iff (rst)
    accept && op == OP_PEEK |=> $stable(wp) && $stable(rp))
    else $error("peek changed a pointer");
`endif

endmodule

// File: hdl/overwrite_ring_fifo.sv
// Top level of the overwrite ring FIFO: pointer unit plus byte storage RAM.
// Depends on owrf_pkg, owrf_ptr and owrf_ram.
//
// Usage:
//   Command channel: drive op, write_byte and peek_offset with start high;
//   the item is taken at the clock edge where start is high and busy is low.
//   Operations: enqueue, dequeue, peek at an offset from the oldest byte.
//   An enqueue into a full FIFO (DEPTH-1 bytes) drops the oldest byte.
//   Result channel: strobe is high for exactly one cycle with read_byte, ok
//   and item_count; the receiver cannot hold it off and must take it then.
//   Latency: the result appears in the cycle after the item is accepted,
//   set by the registered read port of the storage RAM.
//   Throughput: one item per cycle while busy is low, back to back, for every operation.
//   Reset: rst clears both pointers (FIFO empty) and the result strobe; busy
//   is registered from rst, so it is still high in the first cycle after
//   rst is released and the first edge after reset takes no item.
//   Storage contents are not cleared; only written entries are ever read.
module overwrite_ring_fifo #(
  parameter int DEPTH = owrf_pkg::DEFAULT_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [owrf_pkg::OP_W-1:0]   op,
  input  logic [owrf_pkg::BYTE_W-1:0] write_byte,
  input  logic [owrf_pkg::BYTE_W-1:0] peek_offset,
  output logic                        strobe,
  output logic [owrf_pkg::BYTE_W-1:0] read_byte,
  output logic                        ok,
  output logic [owrf_pkg::BYTE_W-1:0] item_count
);
  import owrf_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);

  logic              accept;
  logic              ram_we;
  logic [PTR_W-1:0]  ram_waddr;
  logic [PTR_W-1:0]  ram_raddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic [BYTE_W-1:0] ram_rdata;
  owrf_res_t         res;

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  assign accept = start && !busy;

  owrf_ptr #(
    .DEPTH (DEPTH)
  ) u_ptr (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .op          (op),
    .write_byte  (write_byte),
    .peek_offset (peek_offset),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .res         (res)
  );

  owrf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign strobe     = res.strobe;
  assign ok         = res.ok;
  assign item_count = res.count;
  assign read_byte  = res.rd ? ram_rdata : '0;

endmodule

// File: tb/overwrite_ring_fifo_tb.sv
// Self-checking testbench for overwrite_ring_fifo: enqueue, dequeue, peek and
// reserved-opcode items with random gaps, checked against a ring FIFO predictor in a scoreboard.
// Depends on owrf_pkg and the overwrite_ring_fifo RTL.
module overwrite_ring_fifo_tb;
  import owrf_pkg::*;

  localparam int DEPTH    = DEFAULT_DEPTH;
  localparam int PTR_W    = $clog2(DEPTH);
  localparam int WATCHDOG = 2000;

  localparam logic [OP_W-1:0] OP_RSVD = 2'd3;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [OP_W-1:0]   op;
  logic [BYTE_W-1:0] write_byte;
  logic [BYTE_W-1:0] peek_offset;
  logic              strobe;
  logic [BYTE_W-1:0] read_byte;
  logic              ok;
  logic [BYTE_W-1:0] item_count;

  typedef struct {
    logic [BYTE_W-1:0] rd;
    logic              ok;
    logic [BYTE_W-1:0] cnt;
  } fifo_res_t;

  class fifo_scoreboard;
    logic [BYTE_W-1:0] ring [DEPTH];
    logic [PTR_W-1:0]  wr_ptr;
    logic [PTR_W-1:0]  rd_ptr;
    fifo_res_t         due_q [$];
    int unsigned       errors;

    function new();
      wr_ptr = '0;
      rd_ptr = '0;
      errors = 0;
    endfunction

    function int unsigned fill_level();
      logic [PTR_W-1:0] c;
      c = wr_ptr - rd_ptr;
      return c;
    endfunction

    function int unsigned pending();
      return due_q.size();
    endfunction

    function void note_input(logic [OP_W-1:0] code, logic [BYTE_W-1:0] wb,
                             logic [BYTE_W-1:0] off);
      fifo_res_t        r;
      logic [PTR_W-1:0] nxt;
      logic [PTR_W-1:0] idx;
      r.rd = '0;
      r.ok = 1'b0;
      case (code)
        OP_ENQ: begin
          nxt = wr_ptr + 1'b1;
          if (nxt == rd_ptr) rd_ptr = rd_ptr + 1'b1;
          ring[wr_ptr] = wb;
          wr_ptr = nxt;
          r.ok = 1'b1;
        end
        OP_DEQ: begin
          if (wr_ptr != rd_ptr) begin
            r.rd = ring[rd_ptr];
            rd_ptr = rd_ptr + 1'b1;
            r.ok = 1'b1;
          end
        end
        OP_PEEK: begin
          if (off < fill_level()) begin
            idx = rd_ptr + off;
            r.rd = ring[idx];
            r.ok = 1'b1;
          end
        end
        default: ;
      endcase
      r.cnt = BYTE_W'(fill_level());
      due_q.push_back(r);
    endfunction

    function void check_result(logic [BYTE_W-1:0] rd, logic okb, logic [BYTE_W-1:0] cnt);
      fifo_res_t e;
      if (due_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: read_byte=%h ok=%b item_count=%0d", rd, okb, cnt);
        return;
      end
      e = due_q.pop_front();
      if (rd !== e.rd || okb !== e.ok || cnt !== e.cnt) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch: read_byte exp %h got %h, ok exp %b got %b, ",
                    "item_count exp %0d got %0d"},
                   e.rd, rd, e.ok, okb, e.cnt, cnt);
      end
    endfunction
  endclass

  fifo_scoreboard sb = new();
  int unsigned    idle_cycles;

  overwrite_ring_fifo #(.DEPTH(DEPTH)) i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .op          (op),
    .write_byte  (write_byte),
    .peek_offset (peek_offset),
    .strobe      (strobe),
    .read_byte   (read_byte),
    .ok          (ok),
    .item_count  (item_count)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    logic took;
    took = 1'b0;
    if (!rst) begin
      if (start && !busy) begin
        sb.note_input(op, write_byte, peek_offset);
        took = 1'b1;
      end
      if (strobe) begin
        sb.check_result(read_byte, ok, item_count);
        took = 1'b1;
      end
    end
    idle_cycles = took ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("overwrite_ring_fifo_tb failed");
      $finish;
    end
  end

  function automatic int unsigned pick_gap(bit burst);
    int unsigned r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // call at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(logic [OP_W-1:0] code, logic [BYTE_W-1:0] wb,
                           logic [BYTE_W-1:0] off, int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start       <= 1'b1;
    op          <= code;
    write_byte  <= wb;
    peek_offset <= off;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_phase(int unsigned n, int unsigned enq_pct, int unsigned deq_pct,
                           bit burst);
    int unsigned      r;
    logic [OP_W-1:0]  code;
    logic [BYTE_W-1:0] off;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < enq_pct) code = OP_ENQ;
      else if (r < enq_pct + deq_pct) code = OP_DEQ;
      else if (r < 98) code = OP_PEEK;
      else code = OP_RSVD;
      if ($urandom_range(0, 99) < 60) off = BYTE_W'($urandom_range(0, sb.fill_level()));
      else off = BYTE_W'($urandom_range(0, 255));
      send_item(code, BYTE_W'($urandom_range(0, 255)), off, pick_gap(burst));
    end
  endtask

  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    op          = OP_ENQ;
    write_byte  = '0;
    peek_offset = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_item(OP_DEQ,  8'h3c, 8'h00, 0);
    send_item(OP_PEEK, 8'h00, 8'h00, 0);
    send_item(OP_RSVD, 8'hff, 8'hff, 0);
    send_item(OP_ENQ,  8'h00, 8'hff, 0);
    send_item(OP_ENQ,  8'hff, 8'h00, 1);
    send_item(OP_ENQ,  8'ha5, 8'h5a, 0);
    send_item(OP_ENQ,  8'h5a, 8'ha5, 0);
    send_item(OP_PEEK, 8'h00, 8'h00, 0);
    send_item(OP_PEEK, 8'h11, 8'h03, 2);
    send_item(OP_PEEK, 8'h22, 8'h04, 0);
    send_item(OP_PEEK, 8'h33, 8'hff, 0);
    send_item(OP_RSVD, 8'h00, 8'h00, 0);
    send_item(OP_DEQ,  8'h00, 8'h00, 0);
    send_item(OP_DEQ,  8'hff, 8'hff, 0);
    send_item(OP_DEQ,  8'h00, 8'h00, 3);
    send_item(OP_DEQ,  8'h00, 8'h00, 0);
    send_item(OP_DEQ,  8'h00, 8'h00, 0);
    send_item(OP_ENQ,  8'h80, 8'h80, 0);
    send_item(OP_PEEK, 8'h01, 8'h80, 0);
    send_item(OP_PEEK, 8'h01, 8'h01, 0);

    run_phase(400, 92, 3, 1'b0);
    run_phase(200, 40, 40, 1'b1);
    run_phase(300, 5, 85, 1'b0);
    run_phase(300, 70, 15, 1'b1);
    run_phase(200, 30, 30, 1'b0);

    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    sb.errors += sb.pending();
    if (sb.errors == 0) begin
      $display("overwrite_ring_fifo_tb passed");
    end else begin
      $display("overwrite_ring_fifo_tb failed");
    end
    $finish;
  end

endmodule
